@@ design/gwm_pkg.sv @@
// ----------------------------------------------------------------------------
// gwm_pkg
// shared types and constants for the wildcard glob matcher
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

    localparam int MAX_PATTERN_DEFAULT = 64;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_TEXT   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic shift;
        logic rearm;
    } row_ctl_t;

endpackage

`default_nettype wire

@@ design/gwm_pattern_mem.sv @@
// ----------------------------------------------------------------------------
// gwm_pattern_mem
// pattern byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_pattern_mem #(
    parameter int DEPTH = gwm_pkg::MAX_PATTERN_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/gwm_match_row.sv @@
// ----------------------------------------------------------------------------
// gwm_match_row
// prefix match row held as a circular shift register, one position per cycle while shift is asserted
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_match_row #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT,
    parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gwm_pkg::row_ctl_t ctl,
    input  wire logic [LW-1:0]     len,
    input  wire logic [LW-1:0]     lead_len,
    input  wire logic [LW-1:0]     k,
    input  wire logic [7:0]        append_byte,
    input  wire logic [7:0]        text_byte,
    input  wire logic [7:0]        pat_byte,
    output logic                   last_bit
);

    // bits_reg[i] holds row position i+1
    logic [MAX_PATTERN-1:0] bits_reg;
    logic                   row0_reg;
    logic                   left_old_reg;
    logic                   left_new_reg;
    logic                   last_reg;
    logic                   here_old;
    logic                   here_new;
    logic                   append_bit;

    always_comb
    begin
        here_old   = bits_reg[0];
        append_bit = last_reg && (append_byte == gwm_pkg::STAR_BYTE);
        if (k > len)
        begin
            here_new = here_old;
        end
        else if (pat_byte == gwm_pkg::STAR_BYTE)
        begin
            here_new = left_new_reg | here_old;
        end
        else if ((pat_byte == gwm_pkg::QMARK_BYTE) || (pat_byte == text_byte))
        begin
            here_new = left_old_reg;
        end
        else
        begin
            here_new = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg     <= '0;
            row0_reg     <= 1'b1;
            left_old_reg <= 1'b0;
            left_new_reg <= 1'b0;
            last_reg     <= 1'b1;
        end
        else
        begin
            if (ctl.clear)
            begin
                row0_reg <= 1'b1;
                last_reg <= 1'b1;
            end
            if (ctl.append)
            begin
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    if (len == LW'(i))
                    begin
                        bits_reg[i] <= append_bit;
                    end
                end
                last_reg <= append_bit;
            end
            if (ctl.start)
            begin
                left_old_reg <= row0_reg;
                left_new_reg <= 1'b0;
                row0_reg     <= 1'b0;
                if (len == '0)
                begin
                    last_reg <= 1'b0;
                end
            end
            if (ctl.shift)
            begin
                bits_reg     <= {here_new, bits_reg[MAX_PATTERN-1:1]};
                left_old_reg <= here_old;
                left_new_reg <= here_new;
                if (k == len)
                begin
                    last_reg <= here_new;
                end
            end
            if (ctl.rearm)
            begin
                // prefix matches empty text only while it is all stars
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    bits_reg[i] <= (lead_len > LW'(i));
                end
                row0_reg <= 1'b1;
                last_reg <= (lead_len == len);
            end
        end
    end

    assign last_bit = last_reg;

endmodule

`default_nettype wire

@@ design/wildcard_glob_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// glob matcher with '?' and '*' over a stored pattern and a byte text stream
//
// item channel (item_valid / item_stall) carries kind and char_value:
// clear pattern, append pattern byte, text byte, end of text. a transaction
// is taken on a rising edge with valid high and stall low.
// clear, append and end of text complete when taken, leaving the unit idle. a
// text byte is taken, then the item side stalls while the match row shifts
// past every pattern position, read through the pattern store read port.
// the result channel (result_valid / result_stall) carries matched and
// pattern_overflow; end of text loads the output register, so the result
// shows in the cycle after the end of text transaction.
// a stalled result holds; while it waits, other kinds are still taken and
// only a further end of text is held off.
// reset empties the pattern, clears the overflow flag and arms the row for
// empty text; the pattern store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher_unit #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] char_value,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            matched,
    output logic            pattern_overflow
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    gwm_pkg::state_t   state_reg, state_next;
    gwm_pkg::row_ctl_t row_ctl;
    gwm_pkg::kind_t    kind_in;

    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] lead_reg, lead_next;
    logic [LW-1:0] k_reg, k_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    text_reg, text_next;
    logic          res_valid_reg, res_valid_next;
    logic          matched_reg, matched_next;
    logic          res_ovf_reg, res_ovf_next;

    logic          accept;
    logic          mem_wr_en;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    pat_byte;
    logic          last_bit;

    assign kind_in    = gwm_pkg::kind_t'(kind);
    assign item_stall = (state_reg != gwm_pkg::ST_IDLE) ||
                        ((kind_in == gwm_pkg::KIND_END) && res_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        lead_next      = lead_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        text_next      = text_reg;
        res_valid_next = res_valid_reg;
        matched_next   = matched_reg;
        res_ovf_next   = res_ovf_reg;
        row_ctl        = '0;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            gwm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_in)
                        gwm_pkg::KIND_CLEAR:
                        begin
                            len_next      = '0;
                            lead_next     = '0;
                            ovf_next      = 1'b0;
                            row_ctl.clear = 1'b1;
                        end
                        gwm_pkg::KIND_APPEND:
                        begin
                            if (len_reg == LW'(MAX_PATTERN))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_wr_en      = 1'b1;
                                row_ctl.append = 1'b1;
                                len_next       = len_reg + 1'b1;
                                if ((lead_reg == len_reg) &&
                                    (char_value == gwm_pkg::STAR_BYTE))
                                begin
                                    lead_next = lead_reg + 1'b1;
                                end
                            end
                        end
                        gwm_pkg::KIND_TEXT:
                        begin
                            text_next     = char_value;
                            row_ctl.start = 1'b1;
                            mem_rd_en     = 1'b1;
                            k_next        = LW'(1);
                            state_next    = gwm_pkg::ST_WALK;
                        end
                        gwm_pkg::KIND_END:
                        begin
                            res_valid_next = 1'b1;
                            matched_next   = last_bit;
                            res_ovf_next   = ovf_reg;
                            row_ctl.rearm  = 1'b1;
                        end
                    endcase
                end
            end
            gwm_pkg::ST_WALK:
            begin
                row_ctl.shift = 1'b1;
                if (k_reg < LW'(MAX_PATTERN))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = k_reg[AW-1:0];
                end
                k_next = k_reg + 1'b1;
                if (k_reg == LW'(MAX_PATTERN))
                begin
                    state_next = gwm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwm_pkg::ST_IDLE;
            len_reg       <= '0;
            lead_reg      <= '0;
            k_reg         <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            lead_reg      <= lead_next;
            k_reg         <= k_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg    <= text_next;
        matched_reg <= matched_next;
        res_ovf_reg <= res_ovf_next;
    end

    gwm_pattern_mem #(
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (char_value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (pat_byte)
    );

    gwm_match_row #(
        .MAX_PATTERN (MAX_PATTERN),
        .LW          (LW)
    ) u_row (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (row_ctl),
        .len         (len_reg),
        .lead_len    (lead_reg),
        .k           (k_reg),
        .append_byte (char_value),
        .text_byte   (text_reg),
        .pat_byte    (pat_byte),
        .last_bit    (last_bit)
    );

    assign result_valid     = res_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = res_ovf_reg;

endmodule

`default_nettype wire

@@ design/wildcard_glob_matcher_unit_checker.sv @@
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit_checker
// port level checks for the glob matcher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher_unit_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic [1:0] kind,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic       matched,
    input wire logic       pattern_overflow
);

    logic item_take;

    assign item_take = item_valid && !item_stall;

    // a stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(matched) && $stable(pattern_overflow))
        else $error("result payload changed while stalled");

    // end of text transaction yields a result on the next cycle
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && (kind == gwm_pkg::KIND_END) |=> result_valid)
        else $error("no result after end of text");

    // a text byte keeps the item side busy while the row walks
    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && (kind == gwm_pkg::KIND_TEXT) |=> item_stall)
        else $error("item taken during row walk");

    // a result only appears after an end of text transaction
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(result_valid) && result_valid |->
            $past(item_take) && ($past(kind) == gwm_pkg::KIND_END))
        else $error("result without end of text");

endmodule

bind wildcard_glob_matcher_unit wildcard_glob_matcher_unit_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .kind             (kind),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
);

`default_nettype wire
